// File: hw/rtl/tpl_pkg.sv
package tpl_pkg;

	localparam int NUM_POINTS  = 22;
	localparam int SAMPLE_BITS = 10;
	localparam int IDX_W       = $clog2(NUM_POINTS);
	localparam int TEMP_W      = 12;
	localparam int DIFF_W      = TEMP_W + 1;
	localparam int OFFS_W      = SAMPLE_BITS + 1;
	localparam int PROD_W      = DIFF_W + OFFS_W;
	localparam int MAG_W       = PROD_W - 1;
	localparam int REM_W       = SAMPLE_BITS + 1;
	localparam int SUM_W       = PROD_W + 1;
	localparam int CNT_W       = $clog2(MAG_W);
	localparam int TEMP_MIN    = -512;
	localparam int TEMP_MAX    = 1535;

	// temperature in tenths of a degree, falling
	localparam logic signed [TEMP_W-1:0] PT_TEMP [NUM_POINTS] = '{
		12'sd850, 12'sd800, 12'sd750, 12'sd700, 12'sd650, 12'sd600, 12'sd550,
		12'sd500, 12'sd450, 12'sd400, 12'sd350, 12'sd300, 12'sd250, 12'sd200,
		12'sd150, 12'sd100, 12'sd50, 12'sd0, -12'sd50, -12'sd100, -12'sd150,
		-12'sd200
	};

	// converter reading at each point, strictly rising
	localparam logic [SAMPLE_BITS-1:0] PT_READ [NUM_POINTS] = '{
		10'd129, 10'd146, 10'd165, 10'd186, 10'd210, 10'd236, 10'd267,
		10'd300, 10'd337, 10'd376, 10'd419, 10'd464, 10'd511, 10'd559,
		10'd608, 10'd656, 10'd703, 10'd748, 10'd789, 10'd828, 10'd862,
		10'd892
	};

	typedef struct packed {
		logic load;
		logic search_step;
		logic latch_ops;
		logic mult;
		logic div_step;
		logic finish;
	} tpl_cmd_t;

	typedef struct packed {
		logic hit;
	} tpl_status_t;

endpackage

// File: hw/rtl/tpl_ctrl.sv
module tpl_ctrl
	import tpl_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  tpl_status_t status,
	output tpl_cmd_t    cmd,
	output logic        busy
);

	typedef enum logic [2:0] {
		IDLE,
		SEARCH,
		MULT,
		DIV,
		FINISH
	} state_t;

	state_t           state_q;
	logic [CNT_W-1:0] cnt_q;

	assign busy = (state_q != IDLE);

	always_comb begin
		cmd = '0;
		case (state_q)
			IDLE:    cmd.load        = start;
			SEARCH: begin
				cmd.search_step = !status.hit;
				cmd.latch_ops   = status.hit;
			end
			MULT:    cmd.mult        = 1'b1;
			DIV:     cmd.div_step    = 1'b1;
			FINISH:  cmd.finish      = 1'b1;
			default: cmd             = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= IDLE;
			cnt_q   <= '0;
		end else begin
			case (state_q)
				IDLE: begin
					if (start) state_q <= SEARCH;
				end
				SEARCH: begin
					if (status.hit) state_q <= MULT;
				end
				MULT: begin
					cnt_q   <= CNT_W'(MAG_W - 1);
					state_q <= DIV;
				end
				DIV: begin
					if (cnt_q == '0) state_q <= FINISH;
					else cnt_q <= cnt_q - 1'b1;
				end
				FINISH:  state_q <= IDLE;
				default: state_q <= IDLE;
			endcase
		end
	end

endmodule

// File: hw/rtl/tpl_datapath.sv
module tpl_datapath
	import tpl_pkg::*;
(
	input  logic                     clk,
	input  logic                     arst_n,
	input  tpl_cmd_t                 cmd,
	input  logic [SAMPLE_BITS-1:0]   sample,
	output tpl_status_t              status,
	output logic                     done,
	output logic signed [TEMP_W-1:0] temperature
);

	localparam logic signed [SUM_W-1:0] SUM_MIN = SUM_W'(TEMP_MIN);
	localparam logic signed [SUM_W-1:0] SUM_MAX = SUM_W'(TEMP_MAX);

	logic [SAMPLE_BITS-1:0]   sample_q;
	logic [IDX_W-1:0]         k_q;
	logic signed [DIFF_W-1:0] diff_q;
	logic signed [OFFS_W-1:0] offs_q;
	logic [SAMPLE_BITS-1:0]   den_q;
	logic signed [TEMP_W-1:0] t0_q;
	logic                     neg_q;
	logic [MAG_W-1:0]         quo_q;
	logic [REM_W-1:0]         rem_q;
	logic                     done_q;
	logic signed [TEMP_W-1:0] temp_q;

	logic [IDX_W-1:0]         seg;
	logic [IDX_W-1:0]         lo;
	logic signed [PROD_W-1:0] prod;
	logic [PROD_W-1:0]        prod_abs;
	logic [REM_W-1:0]         rem_sh;
	logic [REM_W-1:0]         rem_diff;
	logic                     q_bit;
	logic signed [SUM_W-1:0]  quo_s;
	logic signed [SUM_W-1:0]  sum;

	assign status.hit = (PT_READ[k_q] > sample_q) || (k_q == IDX_W'(NUM_POINTS - 1));

	// below the table the first segment is used
	assign seg = (k_q == '0) ? IDX_W'(1) : k_q;
	assign lo  = seg - 1'b1;

	assign prod     = diff_q * offs_q;
	assign prod_abs = prod[PROD_W-1] ? (~prod + 1'b1) : prod;

	// restoring division, one quotient bit per step
	assign rem_sh   = {rem_q[REM_W-2:0], quo_q[MAG_W-1]};
	assign rem_diff = rem_sh - {1'b0, den_q};
	assign q_bit    = (rem_sh >= {1'b0, den_q});

	assign quo_s = neg_q ? -$signed({2'b00, quo_q}) : $signed({2'b00, quo_q});
	assign sum   = (den_q == '0) ? SUM_W'(t0_q) : (quo_s + SUM_W'(t0_q));

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			sample_q <= sample;
			k_q      <= '0;
		end
		if (cmd.search_step) k_q <= k_q + 1'b1;
		if (cmd.latch_ops) begin
			diff_q <= DIFF_W'(PT_TEMP[seg]) - DIFF_W'(PT_TEMP[lo]);
			offs_q <= $signed({1'b0, sample_q}) - $signed({1'b0, PT_READ[lo]});
			den_q  <= PT_READ[seg] - PT_READ[lo];
			t0_q   <= PT_TEMP[lo];
		end
		if (cmd.mult) begin
			neg_q <= prod[PROD_W-1];
			quo_q <= prod_abs[MAG_W-1:0];
			rem_q <= '0;
		end
		if (cmd.div_step) begin
			rem_q <= q_bit ? rem_diff : rem_sh;
			quo_q <= {quo_q[MAG_W-2:0], q_bit};
		end
		if (cmd.finish) begin
			if (sum < SUM_MIN)      temp_q <= TEMP_W'(SUM_MIN);
			else if (sum > SUM_MAX) temp_q <= TEMP_W'(SUM_MAX);
			else                    temp_q <= sum[TEMP_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= cmd.finish;
		end
	end

	assign done        = done_q;
	assign temperature = temp_q;

endmodule

// File: hw/rtl/thermistor_piecewise_linear_core.sv
// Thermistor reading to temperature, piecewise-linear over a 22-point table.
// Request channel: drive sample and pulse start while busy is low; the request
// is taken at that clock edge. busy stays high until the result is formed.
// Result channel: done is high for exactly one cycle with temperature (tenths
// of a degree C, two's complement) valid in that cycle. The receiver cannot
// stall; done is not held, though temperature keeps its value until the next result.
// Sequence: the table is scanned one point per cycle (the scan ends where the
// sample falls, and the segment operands are latched in its last cycle),
// then a multiply state (MULT), a bit-serial restoring divider (DIV) and a
// state that adds and saturates (FINISH). done is high in the first cycle
// with busy low, and a new request may be issued in that same cycle. One
// request is in flight at a time, so a new request is taken only once the
// result of the last one is out.
// Reset (arst_n low) returns the controller to idle and clears done; there is
// no table or state to initialize, so the block takes a request right away.
module thermistor_piecewise_linear_core
	import tpl_pkg::*;
(
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	output logic                     busy,
	input  logic [SAMPLE_BITS-1:0]   sample,
	output logic                     done,
	output logic signed [TEMP_W-1:0] temperature
);

	tpl_cmd_t    cmd;
	tpl_status_t status;

	tpl_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.status (status),
		.cmd    (cmd),
		.busy   (busy)
	);

	tpl_datapath u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.sample      (sample),
		.status      (status),
		.done        (done),
		.temperature (temperature)
	);

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("accepted request did not raise busy");

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result strobed while still busy");

	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("done held longer than one cycle");

	a_temp_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> ($signed(temperature) >= -12'sd512 && $signed(temperature) <= 12'sd1535))
		else $error("temperature out of saturation range");

endmodule
